FILE: design/rmq_pkg.sv
package rmq_pkg;

    localparam int ROT_W    = 16;
    localparam int TRANS_W  = 32;
    localparam int QUAT_W   = 16;

    // magnitude square root: 33-bit radicand, 17-bit root
    localparam int T_W      = 17;
    localparam int SQ_IN_W  = T_W + 16;
    localparam int MAG_W    = 17;
    localparam int MSQ_W    = 2 * MAG_W;

    // norm square root: 35-bit sum of squares, 18-bit root
    localparam int SUM_W    = 35;
    localparam int NRM_W    = 18;

    // scaling divide: clamp check plus 14 quotient bits
    localparam int DIV_BITS = 14;
    localparam int NUM_W    = MAG_W + 16;
    localparam int DEN_W    = NRM_W + 1;
    localparam int QMAG_W   = DIV_BITS + 1;
    localparam logic [QMAG_W-1:0] Q_ONE = QMAG_W'(16384);

    // pipeline stage map
    localparam int ST_SQ0      = 1;
    localparam int ST_SQ_LAST  = ST_SQ0 + MAG_W - 1;
    localparam int ST_SQR      = ST_SQ_LAST + 1;
    localparam int ST_SUM      = ST_SQR + 1;
    localparam int ST_NRM0     = ST_SUM + 1;
    localparam int ST_NRM_LAST = ST_NRM0 + NRM_W - 1;
    localparam int ST_DIV0     = ST_NRM_LAST + 1;
    localparam int ST_DIV_LAST = ST_DIV0 + DIV_BITS;
    localparam int ST_OUT      = ST_DIV_LAST + 1;
    localparam int N_ST        = ST_OUT + 1;

    // off-diagonal sign terms
    localparam int SG_21M12 = 0;
    localparam int SG_02M20 = 1;
    localparam int SG_10M01 = 2;
    localparam int SG_10P01 = 3;
    localparam int SG_02P20 = 4;
    localparam int SG_21P12 = 5;
    localparam int SG_N     = 6;

    typedef enum logic [1:0] {
        BIG_W = 2'd0,
        BIG_X = 2'd1,
        BIG_Y = 2'd2,
        BIG_Z = 2'd3
    } big_t;

endpackage

FILE: design/rmq_div_lane.sv
module rmq_div_lane (
    input  logic                              clk,
    input  logic [rmq_pkg::DIV_BITS:0]        en,
    input  logic [rmq_pkg::MAG_W-1:0]         mag,
    input  logic [rmq_pkg::NRM_W-1:0]         norm,
    output logic [rmq_pkg::QMAG_W-1:0]        qmag
);

    localparam int NB = rmq_pkg::DIV_BITS;

    logic [rmq_pkg::NUM_W-1:0] rem_reg [0:NB];
    logic [rmq_pkg::DEN_W-1:0] den_reg [0:NB];
    logic [NB-1:0]             q_reg   [0:NB];
    logic                      ovf_reg [0:NB];

    logic [rmq_pkg::NUM_W-1:0] num_next;
    logic [rmq_pkg::NUM_W-1:0] lim_next;

    // (mag*32768 + N) / (2N), saturating once the quotient reaches 16384
    assign num_next = {mag, 15'b0} + rmq_pkg::NUM_W'(norm);
    assign lim_next = {norm, 15'b0};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num_next;
            den_reg[0] <= {norm, 1'b0};
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num_next >= lim_next);
        end
    end

    for (genvar j = 1; j <= NB; j++)
    begin : g_step
        localparam int B = NB - j;
        logic [rmq_pkg::NUM_W-1:0] sub_next;

        assign sub_next = rmq_pkg::NUM_W'(den_reg[j-1]) << B;

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                if (rem_reg[j-1] >= sub_next)
                begin
                    rem_reg[j] <= rem_reg[j-1] - sub_next;
                    q_reg[j]   <= q_reg[j-1] | (NB'(1) << B);
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
            end
        end
    end

    assign qmag = ovf_reg[NB] ? rmq_pkg::Q_ONE : {1'b0, q_reg[NB]};

endmodule

FILE: design/rotation_matrix_to_quaternion_top.sv
// Rotation matrix (Q1.14) plus translation (Q15.16) in, unit quaternion x,y,z,w
// (Q1.14) plus the unchanged translation out. Fully pipelined: one pose per clock
// while the output is not stalled. It chains the bit-per-stage square roots
// (17 stages for the magnitudes, 18 for the norm) and the 15-stage scaling divide.
// Each stage holds its item until the next one frees up, so bubbles collapse and
// a stalled output never drops or repeats a transfer.
module rotation_matrix_to_quaternion_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // trans_x_in, trans_y_in, trans_z_in
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // trans_x_out, trans_y_out, trans_z_out, quat_x, quat_y, quat_z, quat_w
    output logic [159:0] m_tdata
);

    localparam int NS = rmq_pkg::N_ST;

    typedef struct packed {
        logic [rmq_pkg::TRANS_W-1:0] tz;
        logic [rmq_pkg::TRANS_W-1:0] ty;
        logic [rmq_pkg::TRANS_W-1:0] tx;
        logic [rmq_pkg::SG_N-1:0]    sg;
    } side_t;

    // stall control
    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    assign en[NS] = m_tready;
    for (genvar i = 0; i < NS; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en[i])
                vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NS-1];

    // side data rides along every stage
    side_t side_reg [0:NS-1];
    side_t side_in;

    logic signed [rmq_pkg::ROT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    assign m00 = s_tdata[15:0];
    assign m01 = s_tdata[31:16];
    assign m02 = s_tdata[47:32];
    assign m10 = s_tdata[63:48];
    assign m11 = s_tdata[79:64];
    assign m12 = s_tdata[95:80];
    assign m20 = s_tdata[111:96];
    assign m21 = s_tdata[127:112];
    assign m22 = s_tdata[143:128];

    logic signed [18:0] s_cand [0:3];
    logic [rmq_pkg::T_W-1:0] t_next [0:3];
    logic signed [16:0] d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;

    always_comb
    begin
        s_cand[0] =  19'(m00) + 19'(m11) + 19'(m22) + 19'sd16384;
        s_cand[1] =  19'(m00) - 19'(m11) - 19'(m22) + 19'sd16384;
        s_cand[2] = -19'(m00) + 19'(m11) - 19'(m22) + 19'sd16384;
        s_cand[3] = -19'(m00) - 19'(m11) + 19'(m22) + 19'sd16384;
        for (int k = 0; k < 4; k++)
            t_next[k] = (s_cand[k] > 19'sd0) ? s_cand[k][rmq_pkg::T_W-1:0] : '0;
        d21m12 = 17'(m21) - 17'(m12);
        d02m20 = 17'(m02) - 17'(m20);
        d10m01 = 17'(m10) - 17'(m01);
        s10p01 = 17'(m10) + 17'(m01);
        s02p20 = 17'(m02) + 17'(m20);
        s21p12 = 17'(m21) + 17'(m12);
        side_in.tx = s_tdata[175:144];
        side_in.ty = s_tdata[207:176];
        side_in.tz = s_tdata[239:208];
        side_in.sg[rmq_pkg::SG_21M12] = d21m12[16];
        side_in.sg[rmq_pkg::SG_02M20] = d02m20[16];
        side_in.sg[rmq_pkg::SG_10M01] = d10m01[16];
        side_in.sg[rmq_pkg::SG_10P01] = s10p01[16];
        side_in.sg[rmq_pkg::SG_02P20] = s02p20[16];
        side_in.sg[rmq_pkg::SG_21P12] = s21p12[16];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            side_reg[0] <= side_in;
    end

    for (genvar i = 1; i < NS; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[i])
                side_reg[i] <= side_reg[i-1];
        end
    end

    // magnitude square roots, one root bit per stage, four lanes
    logic [rmq_pkg::SQ_IN_W-1:0] sq_rem_reg  [0:rmq_pkg::ST_SQ_LAST][0:3];
    logic [rmq_pkg::MAG_W-1:0]   sq_root_reg [0:rmq_pkg::ST_SQ_LAST][0:3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 4; k++)
            begin
                sq_rem_reg[0][k]  <= {t_next[k], 16'b0};
                sq_root_reg[0][k] <= '0;
            end
        end
    end

    for (genvar j = rmq_pkg::ST_SQ0; j <= rmq_pkg::ST_SQ_LAST; j++)
    begin : g_sq
        localparam int B = rmq_pkg::ST_SQ_LAST - j;
        for (genvar k = 0; k < 4; k++)
        begin : g_lane
            logic [rmq_pkg::SQ_IN_W+1:0] trial;
            assign trial = ((rmq_pkg::SQ_IN_W+2)'(sq_root_reg[j-1][k]) << (B + 1))
                         + ((rmq_pkg::SQ_IN_W+2)'(1) << (2 * B));
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    if ({2'b0, sq_rem_reg[j-1][k]} >= trial)
                    begin
                        sq_rem_reg[j][k]  <= sq_rem_reg[j-1][k]
                                           - trial[rmq_pkg::SQ_IN_W-1:0];
                        sq_root_reg[j][k] <= sq_root_reg[j-1][k]
                                           | (rmq_pkg::MAG_W'(1) << B);
                    end
                    else
                    begin
                        sq_rem_reg[j][k]  <= sq_rem_reg[j-1][k];
                        sq_root_reg[j][k] <= sq_root_reg[j-1][k];
                    end
                end
            end
        end
    end

    // squares, largest component, signs
    logic [rmq_pkg::MAG_W-1:0] mag_reg [rmq_pkg::ST_SQR:rmq_pkg::ST_NRM_LAST][0:3];
    logic [3:0]                neg_reg [rmq_pkg::ST_SQR:rmq_pkg::ST_DIV_LAST];
    logic [rmq_pkg::MSQ_W-1:0] msq_reg [0:3];
    logic [rmq_pkg::MAG_W-1:0] mg      [0:3];
    rmq_pkg::big_t             big;
    logic [3:0]                neg_next;
    logic [rmq_pkg::SG_N-1:0]  sg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            mg[k] = sq_root_reg[rmq_pkg::ST_SQ_LAST][k];
        sg  = side_reg[rmq_pkg::ST_SQ_LAST].sg;
        big = rmq_pkg::BIG_W;
        if (mg[1] > mg[0])
            big = rmq_pkg::BIG_X;
        if (mg[2] > mg[big])
            big = rmq_pkg::BIG_Y;
        if (mg[3] > mg[big])
            big = rmq_pkg::BIG_Z;
        neg_next = '0;
        unique case (big)
            rmq_pkg::BIG_W:
            begin
                neg_next[1] = sg[rmq_pkg::SG_21M12];
                neg_next[2] = sg[rmq_pkg::SG_02M20];
                neg_next[3] = sg[rmq_pkg::SG_10M01];
            end
            rmq_pkg::BIG_X:
            begin
                neg_next[0] = sg[rmq_pkg::SG_21M12];
                neg_next[2] = sg[rmq_pkg::SG_10P01];
                neg_next[3] = sg[rmq_pkg::SG_02P20];
            end
            rmq_pkg::BIG_Y:
            begin
                neg_next[0] = sg[rmq_pkg::SG_02M20];
                neg_next[1] = sg[rmq_pkg::SG_10P01];
                neg_next[3] = sg[rmq_pkg::SG_21P12];
            end
            default:
            begin
                neg_next[0] = sg[rmq_pkg::SG_10M01];
                neg_next[1] = sg[rmq_pkg::SG_02P20];
                neg_next[2] = sg[rmq_pkg::SG_21P12];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[rmq_pkg::ST_SQR])
        begin
            for (int k = 0; k < 4; k++)
            begin
                msq_reg[k] <= rmq_pkg::MSQ_W'(mg[k]) * rmq_pkg::MSQ_W'(mg[k]);
                mag_reg[rmq_pkg::ST_SQR][k] <= mg[k];
            end
            neg_reg[rmq_pkg::ST_SQR] <= neg_next;
        end
    end

    for (genvar j = rmq_pkg::ST_SUM; j <= rmq_pkg::ST_DIV_LAST; j++)
    begin : g_neg
        always_ff @(posedge clk)
        begin
            if (en[j])
                neg_reg[j] <= neg_reg[j-1];
        end
    end

    for (genvar j = rmq_pkg::ST_SUM; j <= rmq_pkg::ST_NRM_LAST; j++)
    begin : g_mag
        always_ff @(posedge clk)
        begin
            if (en[j])
                for (int k = 0; k < 4; k++)
                    mag_reg[j][k] <= mag_reg[j-1][k];
        end
    end

    // norm square root
    logic [rmq_pkg::SUM_W-1:0] nr_rem_reg  [rmq_pkg::ST_SUM:rmq_pkg::ST_NRM_LAST];
    logic [rmq_pkg::NRM_W-1:0] nr_root_reg [rmq_pkg::ST_SUM:rmq_pkg::ST_NRM_LAST];

    always_ff @(posedge clk)
    begin
        if (en[rmq_pkg::ST_SUM])
        begin
            nr_rem_reg[rmq_pkg::ST_SUM]  <= rmq_pkg::SUM_W'(msq_reg[0])
                                          + rmq_pkg::SUM_W'(msq_reg[1])
                                          + rmq_pkg::SUM_W'(msq_reg[2])
                                          + rmq_pkg::SUM_W'(msq_reg[3]);
            nr_root_reg[rmq_pkg::ST_SUM] <= '0;
        end
    end

    for (genvar j = rmq_pkg::ST_NRM0; j <= rmq_pkg::ST_NRM_LAST; j++)
    begin : g_nrm
        localparam int B = rmq_pkg::ST_NRM_LAST - j;
        logic [rmq_pkg::SUM_W+1:0] trial;
        assign trial = ((rmq_pkg::SUM_W+2)'(nr_root_reg[j-1]) << (B + 1))
                     + ((rmq_pkg::SUM_W+2)'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                if ({2'b0, nr_rem_reg[j-1]} >= trial)
                begin
                    nr_rem_reg[j]  <= nr_rem_reg[j-1] - trial[rmq_pkg::SUM_W-1:0];
                    nr_root_reg[j] <= nr_root_reg[j-1] | (rmq_pkg::NRM_W'(1) << B);
                end
                else
                begin
                    nr_rem_reg[j]  <= nr_rem_reg[j-1];
                    nr_root_reg[j] <= nr_root_reg[j-1];
                end
            end
        end
    end

    // scaling by 1/N, one lane per component
    logic [rmq_pkg::QMAG_W-1:0] qmag [0:3];

    for (genvar k = 0; k < 4; k++)
    begin : g_div
        rmq_div_lane u_div (
            .clk  (clk),
            .en   (en[rmq_pkg::ST_DIV_LAST:rmq_pkg::ST_DIV0]),
            .mag  (mag_reg[rmq_pkg::ST_NRM_LAST][k]),
            .norm (nr_root_reg[rmq_pkg::ST_NRM_LAST]),
            .qmag (qmag[k])
        );
    end

    // output register
    logic [rmq_pkg::QUAT_W-1:0] quat_reg [0:3];

    always_ff @(posedge clk)
    begin
        if (en[rmq_pkg::ST_OUT])
        begin
            for (int k = 0; k < 4; k++)
                quat_reg[k] <= neg_reg[rmq_pkg::ST_DIV_LAST][k]
                             ? rmq_pkg::QUAT_W'(-{1'b0, qmag[k]})
                             : rmq_pkg::QUAT_W'(qmag[k]);
        end
    end

    assign m_tdata = {quat_reg[0], quat_reg[3], quat_reg[2], quat_reg[1],
                      side_reg[NS-1].tz, side_reg[NS-1].ty, side_reg[NS-1].tx};

endmodule

FILE: tb/sv/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_top_tb;

    typedef struct packed {
        logic signed [31:0] tz;
        logic signed [31:0] ty;
        logic signed [31:0] tx;
        logic signed [15:0] r22;
        logic signed [15:0] r21;
        logic signed [15:0] r20;
        logic signed [15:0] r12;
        logic signed [15:0] r11;
        logic signed [15:0] r10;
        logic signed [15:0] r02;
        logic signed [15:0] r01;
        logic signed [15:0] r00;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qz;
        logic signed [15:0] qy;
        logic signed [15:0] qx;
        logic signed [31:0] tz;
        logic signed [31:0] ty;
        logic signed [31:0] tx;
    } quat_pose_t;

    localparam int LATENCY   = 54;
    localparam int MAX_CYCLE = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [239:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;

    quat_pose_t expected_q[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_off_cycles;
    int  err_cnt;
    int  cycle_cnt;

    rotation_matrix_to_quaternion_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] scale_q14(longint unsigned mag, bit neg,
                                              longint unsigned nrm);
        longint unsigned q;
        if (nrm == 0)
            return 16'd0;
        q = (mag * 32768 + nrm) / (2 * nrm);
        if (q > 16384)
            q = 16384;
        return neg ? 16'(-q) : 16'(q);
    endfunction

    function automatic quat_pose_t pose_to_quat(pose_t p);
        int s[4];
        longint unsigned mag[4];
        bit neg[4];
        longint unsigned sumsq;
        longint unsigned nrm;
        rmq_pkg::big_t big;
        quat_pose_t r;
        int m00, m01, m02, m10, m11, m12, m20, m21, m22;
        m00 = p.r00; m01 = p.r01; m02 = p.r02;
        m10 = p.r10; m11 = p.r11; m12 = p.r12;
        m20 = p.r20; m21 = p.r21; m22 = p.r22;
        s[0] =  m00 + m11 + m22 + 16384;
        s[1] =  m00 - m11 - m22 + 16384;
        s[2] = -m00 + m11 - m22 + 16384;
        s[3] = -m00 - m11 + m22 + 16384;
        sumsq = 0;
        neg = '{0, 0, 0, 0};
        for (int k = 0; k < 4; k++)
        begin
            mag[k] = int_sqrt((s[k] > 0 ? longint'(s[k]) : 0) << 16);
            sumsq += mag[k] * mag[k];
        end
        big = rmq_pkg::BIG_W;
        for (int k = 1; k < 4; k++)
            if (mag[k] > mag[big])
                big = rmq_pkg::big_t'(k);
        case (big)
            rmq_pkg::BIG_W:
            begin
                neg[1] = (m21 - m12) < 0;
                neg[2] = (m02 - m20) < 0;
                neg[3] = (m10 - m01) < 0;
            end
            rmq_pkg::BIG_X:
            begin
                neg[0] = (m21 - m12) < 0;
                neg[2] = (m10 + m01) < 0;
                neg[3] = (m02 + m20) < 0;
            end
            rmq_pkg::BIG_Y:
            begin
                neg[0] = (m02 - m20) < 0;
                neg[1] = (m10 + m01) < 0;
                neg[3] = (m21 + m12) < 0;
            end
            default:
            begin
                neg[0] = (m10 - m01) < 0;
                neg[1] = (m20 + m02) < 0;
                neg[2] = (m21 + m12) < 0;
            end
        endcase
        nrm = int_sqrt(sumsq);
        r.tx = p.tx;
        r.ty = p.ty;
        r.tz = p.tz;
        r.qx = scale_q14(mag[1], neg[1], nrm);
        r.qy = scale_q14(mag[2], neg[2], nrm);
        r.qz = scale_q14(mag[3], neg[3], nrm);
        r.qw = scale_q14(mag[0], neg[0], nrm);
        return r;
    endfunction

    // one pose transfer; valid stays high across back-to-back items
    task automatic send_pose(pose_t p);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.insert(expected_q.size(), pose_to_quat(p));
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            3: return 16'sd0;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    function automatic pose_t rand_pose();
        pose_t p;
        p.r00 = rand_elem(); p.r01 = rand_elem(); p.r02 = rand_elem();
        p.r10 = rand_elem(); p.r11 = rand_elem(); p.r12 = rand_elem();
        p.r20 = rand_elem(); p.r21 = rand_elem(); p.r22 = rand_elem();
        p.tx = $urandom;
        p.ty = $urandom;
        p.tz = $urandom;
        return p;
    endfunction

    // matrix with chosen diagonal; off-diagonal entries set to +off or -off
    function automatic pose_t diag_pose(int d0, int d1, int d2, int off);
        pose_t p;
        p = rand_pose();
        p.r00 = 16'(d0); p.r11 = 16'(d1); p.r22 = 16'(d2);
        p.r01 = 16'(off); p.r02 = 16'(-off); p.r10 = 16'(-off);
        p.r12 = 16'(off); p.r20 = 16'(off); p.r21 = 16'(-off);
        return p;
    endfunction

    task automatic test_directed();
        pose_t p;
        send_pose(diag_pose(16384, 16384, 16384, 0));
        send_pose(diag_pose(16384, -16384, -16384, 0));
        send_pose(diag_pose(-16384, 16384, -16384, 0));
        send_pose(diag_pose(-16384, -16384, 16384, 0));
        // ties among the largest candidates
        send_pose(diag_pose(0, 0, 0, 100));
        send_pose(diag_pose(0, 0, -16384, 0));
        send_pose(diag_pose(-16384, -16384, -16384, 0));
        // sign terms: zero, positive, negative
        send_pose(diag_pose(8000, 2000, 1000, 500));
        send_pose(diag_pose(8000, 2000, 1000, -500));
        send_pose(diag_pose(-2000, 9000, -4000, 700));
        send_pose(diag_pose(-3000, -2000, 9000, -700));
        // out-of-range raw values
        send_pose(diag_pose(32767, 32767, 32767, -32768));
        send_pose(diag_pose(-32768, -32768, -32768, 32767));
        send_pose(diag_pose(32767, -32768, 0, 16384));
        p = rand_pose();
        p.tx = 32'h7FFFFFFF; p.ty = 32'h80000000; p.tz = 32'hFFFFFFFF;
        send_pose(p);
        p.tx = 32'h0; p.ty = 32'h55555555; p.tz = 32'hAAAAAAAA;
        send_pose(p);
        p = '1;
        send_pose(p);
        p = '0;
        send_pose(p);
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n)
            send_pose(rand_pose());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 150;
        repeat (90)
            send_pose(rand_pose());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        quat_pose_t got;
        quat_pose_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transfer %h", $time, got);
                err_cnt++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.tx !== exp_r.tx)
                begin
                    $display("%0t: trans_x exp %h got %h", $time, exp_r.tx, got.tx);
                    err_cnt++;
                end
                if (got.ty !== exp_r.ty)
                begin
                    $display("%0t: trans_y exp %h got %h", $time, exp_r.ty, got.ty);
                    err_cnt++;
                end
                if (got.tz !== exp_r.tz)
                begin
                    $display("%0t: trans_z exp %h got %h", $time, exp_r.tz, got.tz);
                    err_cnt++;
                end
                if (got.qx !== exp_r.qx)
                begin
                    $display("%0t: quat_x exp %0d got %0d", $time, exp_r.qx, got.qx);
                    err_cnt++;
                end
                if (got.qy !== exp_r.qy)
                begin
                    $display("%0t: quat_y exp %0d got %0d", $time, exp_r.qy, got.qy);
                    err_cnt++;
                end
                if (got.qz !== exp_r.qz)
                begin
                    $display("%0t: quat_z exp %0d got %0d", $time, exp_r.qz, got.qz);
                    err_cnt++;
                end
                if (got.qw !== exp_r.qw)
                begin
                    $display("%0t: quat_w exp %0d got %0d", $time, exp_r.qw, got.qw);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE)
        begin
            $display("timeout at %0t", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        err_cnt = 0;
        cycle_cnt = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(140, 26, 77);
        test_backpressure();
        // sender pauses until the pipeline is empty
        drain();
        test_random(110, 77, 26);
        test_random(110, 0, 0);
        drain();
        repeat (LATENCY + 10) @(negedge clk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
design/rmq_pkg.sv
design/rmq_div_lane.sv
design/rotation_matrix_to_quaternion_top.sv
tb/sv/rotation_matrix_to_quaternion_top_tb.sv
